@@ rtl/core/tcw_pkg.sv @@
// Package for the text console writer.
// Holds operation codes, character codes and the fixed field widths.
// No dependencies.
package tcw_pkg;

  localparam int FUNC_W = 2;
  localparam int BYTE_W = 8;
  localparam int CUR_COL_W = 7;
  localparam int CUR_ROW_W = 5;
  localparam int CUR_POS_W = 11;
  localparam int CELL_W = 16;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUT    = 2'd0,
    FN_SETPOS = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

  localparam logic [BYTE_W-1:0] BLANK_ATTR_RESET = 8'd7;

  // register index of blank_attr, taken from paddr[2]
  localparam logic REG_BLANK_ATTR = 1'b0;

endpackage

@@ rtl/core/tcw_channels.sv @@
// Valid/ready channel interfaces for the text console writer.
// Depends on tcw_pkg for the payload widths.
interface tcw_in_if
  import tcw_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [BYTE_W-1:0]   char_code;
  logic [BYTE_W-1:0]   attr;
  logic [BYTE_W-1:0]   col;
  logic [BYTE_W-1:0]   row;

  modport source (output valid, func, char_code, attr, col, row, input ready);
  modport sink   (input valid, func, char_code, attr, col, row, output ready);
endinterface

interface tcw_out_if
  import tcw_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CUR_COL_W-1:0] cursor_col;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic [CUR_POS_W-1:0] cursor_pos;
  logic [BYTE_W-1:0]    cell_char;
  logic [BYTE_W-1:0]    cell_attr;

  modport source (output valid, cursor_col, cursor_row, cursor_pos, cell_char, cell_attr,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_pos, cell_char, cell_attr,
                  output ready);
endinterface

@@ rtl/core/text_console_writer_top.sv @@
// Steps, accept to result valid: accept, execute, respond for put without scroll and set
// position; read cell waits for the memory read, clear writes every cell before respond.
// One transaction at a time (accept, execute, respond); the next is taken once the
// screen-memory sequencer is idle again, while a finished result may still wait in the
// output register.
// Scroll runs a read then a write per cell over the two-port (read, write) screen memory.
// Reset (rst_n low, synchronous): cursor to 0,0, blank_attr to 7, screen left unset.
// Holds the screen memory, cursor, sequencer and APB register; uses tcw_pkg, tcw_channels.
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_in_if.sink                in_ch,
  tcw_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int NCELL = ROWS * COLS;
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ROW_W = $clog2(ROWS);
  localparam int AW    = $clog2(NCELL);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_RD_WAIT, ST_CLEAR, ST_SC_RD, ST_SC_WR, ST_FILL, ST_RESP
  } state_t;

  state_t              state_r;
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [BYTE_W-1:0]   blank_attr_r;
  func_t               func_r;
  logic [BYTE_W-1:0]   char_r;
  logic [BYTE_W-1:0]   attr_r;
  logic [COL_W-1:0]    col_in_r;
  logic [ROW_W-1:0]    row_in_r;
  logic [AW-1:0]       cnt_r;
  logic [CELL_W-1:0]   cell_r;
  logic [CELL_W-1:0]   rd_data_r;
  logic                out_valid_r;
  logic [CUR_COL_W-1:0] out_col_r;
  logic [CUR_ROW_W-1:0] out_row_r;
  logic [CUR_POS_W-1:0] out_pos_r;
  logic [BYTE_W-1:0]    out_char_r;
  logic [BYTE_W-1:0]    out_attr_r;

  logic [CELL_W-1:0]   mem [NCELL];
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [CELL_W-1:0]   mem_wd;
  logic [AW-1:0]       mem_ra;

  logic [COL_W-1:0]    col_clamp;
  logic [ROW_W-1:0]    row_clamp;
  logic [AW-1:0]       cur_lin;
  logic [AW-1:0]       rd_lin;
  logic                cfg_wr;
  logic                put_store;

  function automatic logic [AW-1:0] lin_addr(input logic [ROW_W-1:0] r,
                                             input logic [COL_W-1:0] c);
    lin_addr = AW'(AW'(r) * AW'(COLS)) + AW'(c);
  endfunction

  assign col_clamp = (in_ch.col >= 8'(COLS)) ? COL_W'(COLS - 1) : COL_W'(in_ch.col);
  assign row_clamp = (in_ch.row >= 8'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(in_ch.row);
  assign cur_lin   = lin_addr(row_r, col_r);
  assign rd_lin    = lin_addr(row_in_r, col_in_r);
  assign put_store = (func_r == FN_PUT) && (char_r != CH_LF) && (char_r != CH_CR);

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_BLANK_ATTR) ?
                      CFG_DATA_W'(blank_attr_r) : '0;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cursor_pos = out_pos_r;
  assign out_ch.cell_char  = out_char_r;
  assign out_ch.cell_attr  = out_attr_r;

  // memory port control from the sequencer state
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_r;
    mem_wd = {blank_attr_r, CH_SPACE};
    mem_ra = rd_lin;
    unique case (state_r)
      ST_EXEC: begin
        if (put_store) begin
          mem_we = 1'b1;
          mem_wa = cur_lin;
          mem_wd = {attr_r, char_r};
        end
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = {attr_r, CH_SPACE};
      end
      ST_SC_RD: mem_ra = cnt_r + AW'(COLS);
      ST_SC_WR: begin
        mem_we = 1'b1;
        mem_wd = rd_data_r;
      end
      ST_FILL:  mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      blank_attr_r <= BLANK_ATTR_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == REG_BLANK_ATTR) begin
        blank_attr_r <= cfg_pwdata[BYTE_W-1:0];
      end
      // the response state reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != ST_RESP) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            func_r   <= func_t'(in_ch.func);
            char_r   <= in_ch.char_code;
            attr_r   <= in_ch.attr;
            col_in_r <= col_clamp;
            row_in_r <= row_clamp;
            cell_r   <= '0;
            state_r  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cnt_r <= '0;
          unique case (func_r)
            FN_PUT: begin
              if (char_r == CH_CR) begin
                col_r   <= '0;
                state_r <= ST_RESP;
              end else if (char_r != CH_LF && col_r != COL_W'(COLS - 1)) begin
                col_r   <= col_r + COL_W'(1);
                state_r <= ST_RESP;
              end else begin
                // line feed or wrap: next row, scroll when past the bottom
                col_r <= '0;
                if (row_r == ROW_W'(ROWS - 1)) begin
                  state_r <= ST_SC_RD;
                end else begin
                  row_r   <= row_r + ROW_W'(1);
                  state_r <= ST_RESP;
                end
              end
            end
            FN_SETPOS: begin
              col_r   <= col_in_r;
              row_r   <= row_in_r;
              state_r <= ST_RESP;
            end
            FN_CLEAR: state_r <= ST_CLEAR;
            FN_READ:  state_r <= ST_RD_WAIT;
            default:  state_r <= ST_RESP;
          endcase
        end
        ST_RD_WAIT: begin
          cell_r  <= rd_data_r;
          state_r <= ST_RESP;
        end
        ST_CLEAR: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == AW'(NCELL - 1)) begin
            state_r <= ST_RESP;
          end
        end
        ST_SC_RD: state_r <= ST_SC_WR;
        ST_SC_WR: begin
          cnt_r <= cnt_r + AW'(1);
          // after the last copied cell the counter sits on the bottom row
          state_r <= (cnt_r == AW'(NCELL - COLS - 1)) ? ST_FILL : ST_SC_RD;
        end
        ST_FILL: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == AW'(NCELL - 1)) begin
            state_r <= ST_RESP;
          end
        end
        ST_RESP: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_col_r   <= CUR_COL_W'(col_r);
            out_row_r   <= CUR_ROW_W'(row_r);
            out_pos_r   <= CUR_POS_W'(cur_lin);
            out_char_r  <= cell_r[BYTE_W-1:0];
            out_attr_r  <= cell_r[CELL_W-1:BYTE_W];
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
